>>> sv/tpa_pkg.sv
// ----------------------------------------------------------------------------
// Typed resource pool allocator package
// Shared constants, the word that travels down the slot cells and the update
// that the decision stage sends back to them.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int REG_TYPES = 4;
    localparam int TYPE_W    = 2;
    localparam int CNT_W     = 4;
    localparam int SLOT_W    = 3;
    localparam int ID_W      = 8;
    localparam int IDS_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [IDS_W-1:0] IDS_RESET = 64'h0706_0504_0302_0100;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDS_BASE   = 3'd4;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              cmd;
        logic [TYPE_W-1:0] rtype;
        logic              has_pref;
        logic [ID_W-1:0]   pref_id;
        logic [SLOT_W-1:0] rel_slot;
        logic [CNT_W-1:0]  count;
        logic              pref_hit;
        logic [SLOT_W-1:0] pref_slot;
        logic [ID_W-1:0]   pref_gid;
        logic              free_hit;
        logic [SLOT_W-1:0] free_slot;
        logic [ID_W-1:0]   free_gid;
    } token_t;

    typedef struct packed {
        logic              en;
        logic              set;
        logic [TYPE_W-1:0] rtype;
        logic [SLOT_W-1:0] slot;
    } commit_t;

endpackage

>>> sv/tpa_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds the used bits of one slot index for every type and checks the word
// that passes by against them, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module tpa_cell #(
    parameter int NUM_TYPES  = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  tpa_pkg::token_t                               tok_in,
    output tpa_pkg::token_t                               tok_out,
    input  logic [tpa_pkg::REG_TYPES-1:0][tpa_pkg::ID_W-1:0] ids,
    input  tpa_pkg::commit_t                              commit
);
    import tpa_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0]  MY_POS  = CNT_W'(CELL_INDEX);

    logic [NUM_TYPES-1:0] used_reg;
    logic [NUM_TYPES-1:0] used_next;
    token_t               tok_reg;
    token_t               tok_next;
    logic                 used_sel;
    logic                 free;
    logic [ID_W-1:0]      slot_id;

    always_comb
    begin
        used_sel = 1'b0;
        for (int k = 0; k < NUM_TYPES; k++)
        begin
            if (int'(tok_in.rtype) == k)
            begin
                used_sel = used_reg[k];
            end
        end
        slot_id = ids[tok_in.rtype];
        free    = (MY_POS < tok_in.count) && !used_sel;
    end

    always_comb
    begin
        tok_next = tok_reg;
        if (advance)
        begin
            tok_next = tok_in;
            if (tok_in.has_pref && !tok_in.pref_hit && free && (slot_id == tok_in.pref_id))
            begin
                tok_next.pref_hit  = 1'b1;
                tok_next.pref_slot = MY_SLOT;
                tok_next.pref_gid  = slot_id;
            end
            if (!tok_in.free_hit && free)
            begin
                tok_next.free_hit  = 1'b1;
                tok_next.free_slot = MY_SLOT;
                tok_next.free_gid  = slot_id;
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (commit.en && (commit.slot == MY_SLOT))
        begin
            for (int k = 0; k < NUM_TYPES; k++)
            begin
                if (int'(commit.rtype) == k)
                begin
                    used_next[k] = commit.set;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            tok_reg  <= tok_next;
            used_reg <= used_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sv/typed_resource_pool_allocator.sv
// ----------------------------------------------------------------------------
// Typed resource pool allocator
// Grants and releases slots of several resource types from a used-bit map,
// with an optional preferred slot id on each request.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_ stream, one word each: tuser holds the command
// (request or release), tdata the type, preference and release slot.
// One result word per command leaves on the m_ stream: tuser holds ok,
// tdata the granted slot and its id (both zero on failure and on release).
// Each command enters a registered row of SLOTS_PER_TYPE slot cells and moves
// one cell per cycle while the row is not stalled; every cell holds the used
// bits of its slot and checks them on the way. A decision stage at the end of
// the row writes the result register and updates the used bits. A new command
// is accepted once the previous one has reached the result register, so only
// one command is in the row at a time.
// Reset clears every used bit and all counts, and restores the default ids.
// When the receiver stalls, the result waits in the output register while the
// next command is accepted; that command holds at the end of the row until
// the result register frees up. The configuration channel is always ready.
// ----------------------------------------------------------------------------
module typed_resource_pool_allocator #(
    parameter int NUM_TYPES      = 4,
    parameter int SLOTS_PER_TYPE = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // res_type[1:0], has_preference[2], preferred_id[10:3], release_slot[13:11]
    input  logic [15:0]                       s_tdata,
    // command[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // granted_slot[2:0], granted_id[10:3]
    output logic [15:0]                       m_tdata,
    // ok[0]
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tpa_pkg::*;

    logic [REG_TYPES-1:0][CNT_W-1:0] count_reg;
    logic [REG_TYPES-1:0][CNT_W-1:0] count_next;
    logic [REG_TYPES-1:0][IDS_W-1:0] ids_reg;
    logic [REG_TYPES-1:0][IDS_W-1:0] ids_next;

    token_t            entry_reg;
    token_t            entry_next;
    token_t            tok [SLOTS_PER_TYPE+1];
    token_t            last;
    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_ok_reg;
    logic              out_ok_next;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [SLOT_W-1:0] out_slot_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [ID_W-1:0]   out_id_next;

    logic              s_fire;
    logic              stall;
    logic              advance;
    logic              fire;
    logic              dec_ok;
    logic [SLOT_W-1:0] dec_slot;
    logic [ID_W-1:0]   dec_id;
    commit_t           commit;
    logic [CNT_W-1:0]  eff_count;
    logic [SLOTS_PER_TYPE:0] valid_vec;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        ids_next   = ids_reg;
        if (cfg_valid)
        begin
            if (cfg_index < CFG_IDS_BASE)
            begin
                count_next[cfg_index[TYPE_W-1:0]] = cfg_data[CNT_W-1:0];
            end
            else
            begin
                ids_next[cfg_index[TYPE_W-1:0]] = cfg_data;
            end
        end
    end

    // Entry stage.
    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        eff_count = count_reg[s_tdata[TYPE_W-1:0]];
        if (eff_count > CNT_W'(SLOTS_PER_TYPE))
        begin
            eff_count = CNT_W'(SLOTS_PER_TYPE);
        end
        if (int'(s_tdata[TYPE_W-1:0]) >= NUM_TYPES)
        begin
            eff_count = '0;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (s_fire)
        begin
            entry_next           = '0;
            entry_next.valid     = 1'b1;
            entry_next.cmd       = s_tuser;
            entry_next.rtype     = s_tdata[1:0];
            entry_next.has_pref  = s_tdata[2];
            entry_next.pref_id   = s_tdata[10:3];
            entry_next.rel_slot  = s_tdata[13:11];
            entry_next.count     = eff_count;
        end
        else if (advance)
        begin
            entry_next.valid = 1'b0;
        end
    end

    // Row of slot cells.
    assign tok[0] = entry_reg;

    for (genvar i = 0; i < SLOTS_PER_TYPE; i++)
    begin : g_cell
        logic [REG_TYPES-1:0][ID_W-1:0] cell_ids;
        for (genvar k = 0; k < REG_TYPES; k++)
        begin : g_id
            assign cell_ids[k] = ids_reg[k][ID_W*i +: ID_W];
        end
        tpa_cell #(
            .NUM_TYPES  (NUM_TYPES),
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .ids     (cell_ids),
            .commit  (commit)
        );
    end

    // Decision stage.
    assign last    = tok[SLOTS_PER_TYPE];
    assign stall   = last.valid && out_valid_reg && !m_tready;
    assign advance = !stall;
    assign fire    = last.valid && !stall;

    always_comb
    begin
        dec_ok   = 1'b0;
        dec_slot = '0;
        dec_id   = '0;
        if (last.cmd == CMD_RELEASE)
        begin
            dec_ok = ({1'b0, last.rel_slot} < last.count);
        end
        else if (last.pref_hit)
        begin
            dec_ok   = 1'b1;
            dec_slot = last.pref_slot;
            dec_id   = last.pref_gid;
        end
        else if (last.free_hit)
        begin
            dec_ok   = 1'b1;
            dec_slot = last.free_slot;
            dec_id   = last.free_gid;
        end
    end

    always_comb
    begin
        commit.en    = fire && dec_ok;
        commit.set   = (last.cmd == CMD_REQUEST);
        commit.rtype = last.rtype;
        commit.slot  = (last.cmd == CMD_RELEASE) ? last.rel_slot : dec_slot;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_slot_next  = out_slot_reg;
        out_id_next    = out_id_reg;
        if (s_fire)
        begin
            busy_next = 1'b1;
        end
        else if (fire)
        begin
            busy_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = dec_ok;
            out_slot_next  = dec_slot;
            out_id_next    = dec_id;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ids_reg       <= {REG_TYPES{IDS_RESET}};
            entry_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_slot_reg  <= '0;
            out_id_reg    <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            ids_reg       <= ids_next;
            entry_reg     <= entry_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_slot_reg  <= out_slot_next;
            out_id_reg    <= out_id_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {5'b0, out_id_reg, out_slot_reg};

    always_comb
    begin
        for (int i = 0; i <= SLOTS_PER_TYPE; i++)
        begin
            valid_vec[i] = tok[i].valid;
        end
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec))
        else $error("more than one command in the cell row");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (valid_vec == '0))
        else $error("input ready while a command is still in the cell row");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed result carries a nonzero slot or id");
`endif

endmodule

>>> dv/tpa_checker.sv
// ----------------------------------------------------------------------------
// Typed resource pool allocator checker
// Watches the configuration, command and result channels of the allocator.
// It keeps its own copy of the slot counts, slot ids and used-bit map, works
// out the grant for every accepted command word and compares each accepted
// result word with the oldest grant still waiting.
// ----------------------------------------------------------------------------
module tpa_checker #(
    parameter int NUM_TYPES      = 4,
    parameter int SLOTS_PER_TYPE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,
    input  logic                           m_tuser,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    import tpa_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   gid;
    } grant_t;

    logic [CNT_W-1:0] count_cfg [REG_TYPES];
    logic [IDS_W-1:0] ids_cfg   [REG_TYPES];
    logic [7:0]       used_rows [REG_TYPES];

    grant_t pending_grants [$];
    grant_t want;
    grant_t got;

    function automatic grant_t allocate_or_release(
        input logic              cmd,
        input logic [TYPE_W-1:0] rtype,
        input logic              has_pref,
        input logic [ID_W-1:0]   pref_id,
        input logic [SLOT_W-1:0] rel_slot
    );
        grant_t g;
        int     n;
        int     hit;
        g   = '0;
        hit = -1;
        if (rtype >= NUM_TYPES || rtype >= REG_TYPES)
        begin
            return g;
        end
        n = (count_cfg[rtype] > SLOTS_PER_TYPE) ? SLOTS_PER_TYPE : count_cfg[rtype];
        if (n > 8)
        begin
            n = 8;
        end
        if (cmd == CMD_RELEASE)
        begin
            if (rel_slot < n)
            begin
                used_rows[rtype][rel_slot] = 1'b0;
                g.ok = 1'b1;
            end
            return g;
        end
        if (has_pref)
        begin
            for (int s = 0; s < n; s++)
            begin
                if (!used_rows[rtype][s] && ids_cfg[rtype][s*8 +: 8] == pref_id)
                begin
                    hit = s;
                    break;
                end
            end
        end
        if (hit < 0)
        begin
            for (int s = 0; s < n; s++)
            begin
                if (!used_rows[rtype][s])
                begin
                    hit = s;
                    break;
                end
            end
        end
        if (hit >= 0)
        begin
            used_rows[rtype][hit] = 1'b1;
            g.ok   = 1'b1;
            g.slot = hit[SLOT_W-1:0];
            g.gid  = ids_cfg[rtype][hit*8 +: 8];
        end
        return g;
    endfunction

    task automatic note_failure(input string msg);
        if (mismatches < 10)
        begin
            $display("%s", msg);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < REG_TYPES; t++)
            begin
                count_cfg[t] = '0;
                ids_cfg[t]   = IDS_RESET;
                used_rows[t] = '0;
            end
            pending_grants.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < CFG_IDS_BASE)
                begin
                    count_cfg[cfg_index[TYPE_W-1:0]] = cfg_data[CNT_W-1:0];
                end
                else
                begin
                    ids_cfg[cfg_index[TYPE_W-1:0]] = cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = '{ok: m_tuser, slot: m_tdata[2:0], gid: m_tdata[10:3]};
                if (pending_grants.size() == 0)
                begin
                    note_failure($sformatf("unexpected result word: ok %0d slot %0d id %02h",
                                           got.ok, got.slot, got.gid));
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (want.ok !== got.ok || want.slot !== got.slot || want.gid !== got.gid)
                    begin
                        note_failure($sformatf(
                            "mismatch: exp ok %0d slot %0d id %02h, got ok %0d slot %0d id %02h",
                            want.ok, want.slot, want.gid, got.ok, got.slot, got.gid));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_grants.push_back(allocate_or_release(s_tuser, s_tdata[1:0], s_tdata[2],
                                                             s_tdata[10:3], s_tdata[13:11]));
            end
            outstanding <= outstanding + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
        end
    end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Typed resource pool allocator testbench
// Drives request and release words in random bursts against a receiver that
// stalls on its own pattern, reprograms slot counts and ids between phases
// while the block is idle, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb;

    import tpa_pkg::*;

    localparam int NUM_TYPES      = 4;
    localparam int SLOTS_PER_TYPE = 8;
    localparam int DRAIN_CYCLES   = SLOTS_PER_TYPE + 4;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 128;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    logic [IDS_W-1:0]      ids_written [REG_TYPES];
    int                    burst_left;

    typed_resource_pool_allocator #(
        .NUM_TYPES      (NUM_TYPES),
        .SLOTS_PER_TYPE (SLOTS_PER_TYPE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tpa_checker #(
        .NUM_TYPES      (NUM_TYPES),
        .SLOTS_PER_TYPE (SLOTS_PER_TYPE)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        stall_mode_t mode;
        int          left;
        int          hold;
        m_tready = 1'b0;
        mode     = READY_ALWAYS;
        left     = 0;
        hold     = 0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(50, 300);
            end
            left--;
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (hold > 0)
                    begin
                        hold--;
                        m_tready <= 1'b0;
                    end
                    else
                    begin
                        m_tready <= 1'b1;
                        hold = $urandom_range(0, 15);
                    end
                end
            endcase
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    task automatic send_cmd(
        input logic              cmd,
        input logic [TYPE_W-1:0] rtype,
        input logic              has_pref,
        input logic [ID_W-1:0]   pref_id,
        input logic [SLOT_W-1:0] rel_slot
    );
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, rel_slot, pref_id, has_pref, rtype};
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(0, 20);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx >= CFG_IDS_BASE)
        begin
            ids_written[idx[TYPE_W-1:0]] = val;
        end
    endtask

    task automatic random_cmd(input int release_pct);
        logic [TYPE_W-1:0] rtype;
        logic              cmd;
        logic [ID_W-1:0]   pref_id;
        int                pick;
        rtype = TYPE_W'($urandom_range(0, REG_TYPES - 1));
        cmd   = ($urandom_range(0, 99) < release_pct) ? CMD_RELEASE : CMD_REQUEST;
        pick  = $urandom_range(0, 7);
        if ($urandom_range(0, 9) < 7)
        begin
            pref_id = ids_written[rtype][pick*8 +: 8];
        end
        else
        begin
            pref_id = ID_W'($urandom);
        end
        send_cmd(cmd, rtype, 1'($urandom_range(0, 1)), pref_id,
                 SLOT_W'($urandom_range(0, 7)));
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] val;
        logic [CNT_W-1:0]      cnt;
        for (int t = 0; t < REG_TYPES; t++)
        begin
            case ($urandom_range(0, 5))
                0:       cnt = 4'd0;
                1:       cnt = 4'd8;
                2:       cnt = 4'd15;
                3:       cnt = 4'd1;
                default: cnt = CNT_W'($urandom_range(0, 15));
            endcase
            val = {$urandom, $urandom};
            val[CNT_W-1:0] = cnt;
            write_reg(CFG_COUNT_BASE + CFG_IDX_W'(t), val);
        end
        for (int t = 0; t < REG_TYPES; t++)
        begin
            case ($urandom_range(0, 4))
                0:       val = '0;
                1:       val = '1;
                2:       val = {$urandom, $urandom};
                default:
                begin
                    for (int b = 0; b < 8; b++)
                    begin
                        case ($urandom_range(0, 2))
                            0:       val[b*8 +: 8] = 8'h00;
                            1:       val[b*8 +: 8] = 8'h5A;
                            default: val[b*8 +: 8] = 8'hFF;
                        endcase
                    end
                end
            endcase
            write_reg(CFG_IDS_BASE + CFG_IDX_W'(t), val);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        for (int t = 0; t < REG_TYPES; t++)
        begin
            ids_written[t] = IDS_RESET;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'h00, 3'd0);
        send_cmd(CMD_RELEASE, 2'd1, 1'b0, 8'h00, 3'd0);
        drain();

        write_reg(CFG_COUNT_BASE + 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_COUNT_BASE + 3'd1, 64'd3);
        write_reg(CFG_COUNT_BASE + 3'd2, 64'd8);
        write_reg(CFG_COUNT_BASE + 3'd3, 64'd1);
        write_reg(CFG_IDS_BASE + 3'd0, 64'hFF00_AAAA_00AA_01AA);
        write_reg(CFG_IDS_BASE + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_IDS_BASE + 3'd2, 64'h0000_0000_0000_0000);
        write_reg(CFG_IDS_BASE + 3'd3, 64'h1234_5678_9ABC_DEF0);

        send_cmd(CMD_REQUEST, 2'd0, 1'b0, 8'hFF, 3'd7);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'hAA, 3'd0);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'hAA, 3'd0);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'hFF, 3'd0);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'hAA, 3'd0);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'hAA, 3'd0);
        send_cmd(CMD_RELEASE, 2'd0, 1'b1, 8'hFF, 3'd7);
        send_cmd(CMD_RELEASE, 2'd0, 1'b0, 8'h00, 3'd7);
        send_cmd(CMD_REQUEST, 2'd0, 1'b1, 8'h00, 3'd0);
        send_cmd(CMD_REQUEST, 2'd2, 1'b1, 8'h00, 3'd0);
        send_cmd(CMD_REQUEST, 2'd2, 1'b1, 8'hFF, 3'd0);
        send_cmd(CMD_REQUEST, 2'd3, 1'b0, 8'h00, 3'd0);
        send_cmd(CMD_REQUEST, 2'd3, 1'b0, 8'h00, 3'd0);
        send_cmd(CMD_RELEASE, 2'd3, 1'b0, 8'h00, 3'd7);
        send_cmd(CMD_RELEASE, 2'd3, 1'b0, 8'h00, 3'd0);
        repeat (4)
        begin
            send_cmd(CMD_REQUEST, 2'd1, 1'b1, 8'hFF, 3'd0);
        end
        drain();

        write_reg(CFG_COUNT_BASE + 3'd1, 64'd1);
        send_cmd(CMD_RELEASE, 2'd1, 1'b0, 8'h00, 3'd2);
        send_cmd(CMD_REQUEST, 2'd1, 1'b0, 8'h00, 3'd0);
        drain();

        write_reg(CFG_COUNT_BASE + 3'd1, 64'd3);
        send_cmd(CMD_RELEASE, 2'd1, 1'b0, 8'h00, 3'd2);
        send_cmd(CMD_REQUEST, 2'd1, 1'b1, 8'hFF, 3'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            int release_pct;
            drain();
            random_config();
            release_pct = $urandom_range(20, 70);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                random_cmd(release_pct);
            end
        end
        drain();

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
